[rtl/vector3_alu_defines.svh]
`ifndef VECTOR3_ALU_DEFINES_SVH
`define VECTOR3_ALU_DEFINES_SVH

// Same-cycle implication, clocked by i_clk, off while i_rst_n is low.
`define V3A_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define V3A_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/v3a_pkg.sv]
package v3a_pkg;

    localparam int CW       = 32;            // component width
    localparam int FB       = 16;            // fraction bits
    localparam int PW       = 2 * CW;        // product width
    localparam int XW       = PW + 2;        // widest combined value
    localparam int RW       = CW + 2;        // sqrt remainder
    localparam int DW       = CW + 1;        // divider remainder
    localparam int QW       = FB + 1;        // normalized component magnitude
    localparam int SQ_STEPS = CW;
    localparam int DV_STEPS = QW;
    localparam int SIDE_LEN = SQ_STEPS + 1 + DV_STEPS;

    localparam logic [2:0] CMD_SUM   = 3'd0;
    localparam logic [2:0] CMD_SCALE = 3'd1;
    localparam logic [2:0] CMD_DOT   = 3'd2;
    localparam logic [2:0] CMD_CROSS = 3'd3;
    localparam logic [2:0] CMD_MAG   = 3'd4;
    localparam logic [2:0] CMD_NORM  = 3'd5;

    localparam logic [XW-1:0] HALF    = XW'(1) << (FB - 1);
    localparam logic [XW-1:0] NEG_LIM = XW'(1) << (CW - 1);
    localparam logic [XW-1:0] POS_LIM = (XW'(1) << (CW - 1)) - XW'(1);
    localparam logic [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_NEG = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [CW-1:0] sc;
        logic          zero;
        logic          sat;
    } t_res;

    typedef struct packed {
        logic [PW-1:0] rad;
        logic [RW-1:0] rem;
        logic [CW-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [CW-1:0]         m;
        logic [2:0][DW-1:0]    r;
        logic [2:0][QW-1:0]    q;
    } t_dv;

    typedef struct packed {
        logic               v;
        logic [2:0]         cmd;
        t_res               res;
        logic [2:0]         neg;
        logic [2:0][CW-1:0] mag;
    } t_side;

    typedef struct packed {
        logic [CW-1:0] val;
        logic          sat;
    } t_rs;

    // Round to nearest (ties away from zero) when rnd, then clip to CW bits.
    function automatic t_rs rnd_sat(input logic [XW-1:0] v, input logic rnd);
        logic [XW-1:0] mg;
        logic [XW-1:0] rm;
        t_rs           r;
        mg = v[XW-1] ? (~v + XW'(1)) : v;
        rm = rnd ? ((mg + HALF) >> FB) : mg;
        if (v[XW-1]) begin
            r.sat = rm > NEG_LIM;
            r.val = r.sat ? MIN_NEG : (~rm[CW-1:0]) + CW'(1);
        end else begin
            r.sat = rm > POS_LIM;
            r.val = r.sat ? MAX_POS : rm[CW-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/v3a_chan_if.sv]
interface v3a_in_if import v3a_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [2:0]    cmd;
    logic [CW-1:0] a_x;
    logic [CW-1:0] a_y;
    logic [CW-1:0] a_z;
    logic [CW-1:0] b_x;
    logic [CW-1:0] b_y;
    logic [CW-1:0] b_z;
    logic [CW-1:0] scale_factor;

    modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                    input ready);
    modport sink   (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                    output ready);
endinterface

interface v3a_out_if import v3a_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [CW-1:0] res_x;
    logic [CW-1:0] res_y;
    logic [CW-1:0] res_z;
    logic [CW-1:0] scalar_out;
    logic          zero_length;
    logic          saturated;

    modport source (output valid, res_x, res_y, res_z, scalar_out, zero_length, saturated,
                    input ready);
    modport sink   (input valid, res_x, res_y, res_z, scalar_out, zero_length, saturated,
                    output ready);
endinterface

[rtl/v3a_front.sv]
module v3a_front import v3a_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_v,
    input  logic [2:0]         i_cmd,
    input  logic [2:0][CW-1:0] i_a,
    input  logic [2:0][CW-1:0] i_b,
    input  logic [CW-1:0]      i_s,
    output t_side              o_side,
    output logic [PW-1:0]      o_rad
);

    // stage 1: captured beat
    logic               r1_v;
    logic [2:0]         r1_cmd;
    logic [2:0][CW-1:0] r1_a, r1_b;
    logic [CW-1:0]      r1_s;

    // stage 2: products
    logic               r2_v;
    logic [2:0]         r2_cmd;
    logic [5:0][PW-1:0] r2_p;
    logic [2:0][CW:0]   r2_sum;
    logic [2:0]         r2_neg;
    logic [2:0][CW-1:0] r2_mag;

    // stage 3: combined values
    logic               r3_v;
    logic [2:0]         r3_cmd;
    logic [2:0][XW-1:0] r3_val;
    logic [XW-1:0]      r3_sc;
    logic [PW-1:0]      r3_rad;
    logic [2:0]         r3_neg;
    logic [2:0][CW-1:0] r3_mag;

    t_side              r4_side;

    logic [5:0][CW-1:0] op_l, op_r;
    logic [5:0][PW-1:0] n2_p;
    logic [2:0][CW:0]   n2_sum;
    logic [2:0]         n2_neg;
    logic [2:0][CW-1:0] n2_mag;
    logic [2:0][XW-1:0] n3_val;
    logic [XW-1:0]      n3_sc;
    logic [5:0][XW-1:0] p_ext;
    t_rs                rs [3];
    t_rs                rsc;
    t_side              n4_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            op_l[k] = r1_a[k];
            unique case (r1_cmd)
                CMD_SCALE:         op_r[k] = r1_s;
                CMD_MAG, CMD_NORM: op_r[k] = r1_a[k];
                default:           op_r[k] = r1_b[k];
            endcase
            op_l[k+3] = r1_a[k];
            op_r[k+3] = r1_b[k];
        end
        // cross lanes: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx
        if (r1_cmd == CMD_CROSS) begin
            op_l = {r1_a[1], r1_a[0], r1_a[0], r1_a[2], r1_a[2], r1_a[1]};
            op_r = {r1_b[0], r1_b[1], r1_b[2], r1_b[0], r1_b[1], r1_b[2]};
        end
        for (int k = 0; k < 6; k++) begin
            n2_p[k] = $signed({{CW{op_l[k][CW-1]}}, op_l[k]})
                    * $signed({{CW{op_r[k][CW-1]}}, op_r[k]});
        end
        for (int k = 0; k < 3; k++) begin
            n2_sum[k] = {r1_a[k][CW-1], r1_a[k]} + {r1_b[k][CW-1], r1_b[k]};
            n2_neg[k] = r1_a[k][CW-1];
            n2_mag[k] = r1_a[k][CW-1] ? (~r1_a[k] + CW'(1)) : r1_a[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            p_ext[k] = {{2{r2_p[k][PW-1]}}, r2_p[k]};
        end
        n3_sc = '0;
        for (int k = 0; k < 3; k++) begin
            unique case (r2_cmd)
                CMD_SUM:   n3_val[k] = {{(XW-CW-1){r2_sum[k][CW]}}, r2_sum[k]};
                CMD_SCALE: n3_val[k] = p_ext[k];
                CMD_CROSS: n3_val[k] = p_ext[2*k] - p_ext[2*k+1];
                default:   n3_val[k] = '0;
            endcase
        end
        if (r2_cmd == CMD_DOT) begin
            n3_sc = p_ext[0] + p_ext[1] + p_ext[2];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rs[k] = rnd_sat(r3_val[k], r3_cmd != CMD_SUM);
        end
        rsc = rnd_sat(r3_sc, 1'b1);
        n4_side.v        = r3_v;
        n4_side.cmd      = r3_cmd;
        n4_side.res.x    = rs[0].val;
        n4_side.res.y    = rs[1].val;
        n4_side.res.z    = rs[2].val;
        n4_side.res.sc   = rsc.val;
        n4_side.res.zero = 1'b0;
        n4_side.res.sat  = rs[0].sat | rs[1].sat | rs[2].sat | rsc.sat;
        n4_side.neg      = r3_neg;
        n4_side.mag      = r3_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_side.v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_v;
            r1_cmd  <= i_cmd;
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_s    <= i_s;
            r2_v    <= r1_v;
            r2_cmd  <= r1_cmd;
            r2_p    <= n2_p;
            r2_sum  <= n2_sum;
            r2_neg  <= n2_neg;
            r2_mag  <= n2_mag;
            r3_v    <= r2_v;
            r3_cmd  <= r2_cmd;
            r3_val  <= n3_val;
            r3_sc   <= n3_sc;
            // squares are non-negative and their sum stays below 2^64
            r3_rad  <= r2_p[0] + r2_p[1] + r2_p[2];
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;
            r4_side <= n4_side;
        end
    end

    assign o_side = r4_side;
    assign o_rad  = r3_rad;

endmodule

[rtl/v3a_sqrt_cell.sv]
module v3a_sqrt_cell import v3a_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_sq  i_d,
    output t_sq  o_q
);

    t_sq             r_q;
    t_sq             n_q;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;
    logic            ge;

    // one root bit per cell: bring down two radicand bits, try (root<<2)|1
    always_comb begin
        cur        = {i_d.rem, i_d.rad[PW-1 -: 2]};
        trial      = (RW+2)'({i_d.root, 2'b01});
        ge         = cur >= trial;
        n_q.rem    = RW'(ge ? (cur - trial) : cur);
        n_q.root   = {i_d.root[CW-2:0], ge};
        n_q.rad    = i_d.rad << 2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[rtl/v3a_div_cell.sv]
module v3a_div_cell import v3a_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_dv  i_d,
    output t_dv  o_q
);

    t_dv              r_q;
    t_dv              n_q;
    logic [DW-1:0]    dm;
    logic [DW-1:0]    t;
    logic             ge;

    // one quotient bit per cell on three lanes sharing the divisor;
    // remainder leaves already doubled for the next bit
    always_comb begin
        dm      = DW'(i_d.m);
        n_q.m   = i_d.m;
        t       = '0;
        ge      = 1'b0;
        for (int k = 0; k < 3; k++) begin
            ge        = i_d.r[k] >= dm;
            t         = ge ? (i_d.r[k] - dm) : i_d.r[k];
            n_q.r[k]  = {t[DW-2:0], 1'b0};
            n_q.q[k]  = {i_d.q[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[rtl/vector3_alu.sv]
// Fixed-point 3D vector unit, signed Q16.16 components.
// Input channel i_in: cmd plus vectors a, b and scale_factor, one beat per item.
// Output channel o_out: res_x/y/z, scalar_out, zero_length, saturated, one beat
// per input beat, in order.
// cmd: sum, scale, dot, cross, magnitude, normalize; codes 6 and 7 give all zeros.
// Throughput: one beat per cycle while ready is high. On the way to o_out.valid
// a beat passes the input register, a multiply and a combine stage, a chain of
// 32 square-root cells (one root bit each), one magnitude rounding stage, a
// chain of 17 divider cells (one quotient bit each, three lanes) and the output
// register.
// Ready is low only while the skid register holds a beat; a single waiting
// result does not stop input. When the receiver stalls, the output register
// and then the skid fill, after which the whole pipeline freezes in place.
// Reset (synchronous, active low) empties the pipeline and both output
// registers; there is no other state.
`include "vector3_alu_defines.svh"

module vector3_alu import v3a_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    v3a_in_if.sink      i_in,
    v3a_out_if.source   o_out
);

    localparam int MAG_IDX = SQ_STEPS;

    logic               en;
    t_side              w_sd [0:SIDE_LEN-1];
    t_side              r_sd [1:SIDE_LEN-1];
    t_side              n_sd [1:SIDE_LEN-1];
    logic [PW-1:0]      rad;
    t_sq                w_sq [0:SQ_STEPS];
    t_dv                w_dv [0:DV_STEPS];
    t_dv                r_dv0;
    t_dv                n_dv0;
    logic [CW-1:0]      m_rnd;
    logic               m_ovf;
    logic [2:0][CW-1:0] qq;
    logic [2:0][CW-1:0] nv;
    t_res               fin;
    logic               fin_v;
    logic               r_ov, r_sv;
    t_res               r_out, r_skid;
    logic               pop;
    logic               out_clear;

    assign en         = !r_sv;
    assign i_in.ready = en;

    v3a_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (i_in.valid),
        .i_cmd   (i_in.cmd),
        .i_a     ({i_in.a_z, i_in.a_y, i_in.a_x}),
        .i_b     ({i_in.b_z, i_in.b_y, i_in.b_x}),
        .i_s     (i_in.scale_factor),
        .o_side  (w_sd[0]),
        .o_rad   (rad)
    );

    assign w_sq[0] = '{rad: rad, rem: '0, root: '0};

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        v3a_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_sq[k]),
            .o_q   (w_sq[k+1])
        );
    end

    assign w_dv[0] = r_dv0;

    for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
        v3a_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (w_dv[k]),
            .o_q   (w_dv[k+1])
        );
    end

    for (genvar k = 1; k < SIDE_LEN; k++) begin : g_sdw
        assign w_sd[k] = r_sd[k];
    end

    // side line; magnitude result and divider operands join at MAG_IDX
    always_comb begin
        for (int k = 1; k < SIDE_LEN; k++) begin
            n_sd[k] = w_sd[k-1];
        end
        // round to nearest: floor root plus one when remainder exceeds root
        m_rnd = w_sq[SQ_STEPS].root
              + CW'(w_sq[SQ_STEPS].rem > RW'(w_sq[SQ_STEPS].root));
        m_ovf = m_rnd[CW-1];
        if (w_sd[MAG_IDX-1].cmd == CMD_MAG) begin
            n_sd[MAG_IDX].res.sc  = m_ovf ? MAX_POS : m_rnd;
            n_sd[MAG_IDX].res.sat = m_ovf;
        end
        n_dv0.m = m_rnd;
        for (int k = 0; k < 3; k++) begin
            n_dv0.r[k] = {1'b0, w_sd[MAG_IDX-1].mag[k]};
            n_dv0.q[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_sd[k].v <= 1'b0;
            end
        end else if (en) begin
            r_sd  <= n_sd;
            r_dv0 <= n_dv0;
        end
    end

    // final rounding of the normalized components; |a_i| <= |a| keeps them small
    always_comb begin
        fin   = w_sd[SIDE_LEN-1].res;
        fin_v = w_sd[SIDE_LEN-1].v;
        for (int k = 0; k < 3; k++) begin
            qq[k] = CW'(w_dv[DV_STEPS].q[k])
                  + CW'(w_dv[DV_STEPS].r[k] >= DW'(w_dv[DV_STEPS].m));
            nv[k] = w_sd[SIDE_LEN-1].neg[k] ? (~qq[k] + CW'(1)) : qq[k];
        end
        if (w_sd[SIDE_LEN-1].cmd == CMD_NORM) begin
            if (w_dv[DV_STEPS].m == '0) begin
                fin.zero = 1'b1;
            end else begin
                fin.x = nv[0];
                fin.y = nv[1];
                fin.z = nv[2];
            end
        end
    end

    assign pop = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (pop) begin
                if (r_sv) begin
                    r_out <= r_skid;
                    r_sv  <= 1'b0;
                end else begin
                    r_ov  <= 1'b0;
                end
            end
            if (en && fin_v) begin
                if (!r_ov || pop) begin
                    r_out <= fin;
                    r_ov  <= 1'b1;
                end else begin
                    r_skid <= fin;
                    r_sv   <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.res_x       = r_out.x;
    assign o_out.res_y       = r_out.y;
    assign o_out.res_z       = r_out.z;
    assign o_out.scalar_out  = r_out.sc;
    assign o_out.zero_length = r_out.zero;
    assign o_out.saturated   = r_out.sat;

    assign out_clear = r_out.x == '0 && r_out.y == '0 && r_out.z == '0 && !r_out.sat;

    `V3A_AST_IMP(a_skid_needs_out, r_sv, r_ov, "skid holds a beat with output empty")
    `V3A_AST_NXT(a_beat_held, r_ov && !o_out.ready, r_ov, "stalled output beat dropped")
    `V3A_AST_IMP(a_zero_len_clean, r_ov && r_out.zero, out_clear, "zero length beat has data")

endmodule
